// ===== rtl/sflm_pkg.sv =====
package sflm_pkg;

	localparam int CHANNELS = 16;
	localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int CH_W = 4;
	localparam int ADC_W = 12;
	localparam int TEMP_W = 12;
	localparam int LVL_W = 12;
	localparam int CONFIRM_W = 3;
	localparam int CNT_W = 4;
	localparam int PHASE_W = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [LVL_W-1:0] OPEN_LEVEL_RST = 12'd3500;
	localparam logic [LVL_W-1:0] SHORT_LEVEL_RST = 12'd10;
	localparam logic [CONFIRM_W-1:0] CONFIRM_RST = 3'd3;

	localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;
	localparam logic [PHASE_W-1:0] PHASE_LAST = 5'd19;
	localparam logic [PHASE_W-1:0] SLOW_HALF = 5'd10;
	localparam logic [PHASE_W-1:0] SLOW_PERIOD = 5'd20;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_OPEN   = 2'd1,
		MODE_SHORT  = 2'd2,
		MODE_OVER   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		LED_KEEP = 2'd0,
		LED_ON   = 2'd1,
		LED_OFF  = 2'd2
	} led_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OPEN_LEVEL    = 2'd0,
		CFG_SHORT_LEVEL   = 2'd1,
		CFG_CONFIRM_COUNT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [LVL_W-1:0]     open_level;
		logic [LVL_W-1:0]     short_level;
		logic [CONFIRM_W-1:0] confirm_count;
	} cfg_t;

	// per-channel entry held in the state memory
	typedef struct packed {
		mode_t            mode;
		logic [CNT_W-1:0] count;
	} chan_state_t;

	typedef struct packed {
		logic             en;
		logic [CH_AW-1:0] addr;
	} ram_rd_t;

	typedef struct packed {
		logic             en;
		logic [CH_AW-1:0] addr;
		chan_state_t      data;
	} ram_wr_t;

endpackage

// ===== rtl/sflm_if.sv =====
interface sflm_in_if;
	logic                               valid;
	logic                               ready;
	logic [sflm_pkg::CH_W-1:0]          channel;
	logic [sflm_pkg::ADC_W-1:0]         adc_mid;
	logic signed [sflm_pkg::TEMP_W-1:0] temperature;
	logic signed [sflm_pkg::TEMP_W-1:0] threshold;
	logic                               scan_last;

	modport source (output valid, channel, adc_mid, temperature, threshold, scan_last,
		input ready);
	modport sink (input valid, channel, adc_mid, temperature, threshold, scan_last,
		output ready);
endinterface

interface sflm_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] led_action;
	logic [1:0] mode_now;
	logic       relay_update;
	logic       relay_on;

	modport source (output valid, led_action, mode_now, relay_update, relay_on,
		input ready);
	modport sink (input valid, led_action, mode_now, relay_update, relay_on,
		output ready);
endinterface

// ===== rtl/sflm_cfg_regs.sv =====
module sflm_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sflm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sflm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output sflm_pkg::cfg_t                      cfg
);
	import sflm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_level    <= OPEN_LEVEL_RST;
			cfg_q.short_level   <= SHORT_LEVEL_RST;
			cfg_q.confirm_count <= CONFIRM_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_OPEN_LEVEL:    cfg_q.open_level    <= cfg_wdata[LVL_W-1:0];
				CFG_SHORT_LEVEL:   cfg_q.short_level   <= cfg_wdata[LVL_W-1:0];
				CFG_CONFIRM_COUNT: cfg_q.confirm_count <= cfg_wdata[CONFIRM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/sflm_state_ram.sv =====
module sflm_state_ram (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sflm_pkg::ram_rd_t     rd,
	input  sflm_pkg::ram_wr_t     wr,
	output sflm_pkg::chan_state_t rd_data
);
	import sflm_pkg::*;

	chan_state_t      mem [CHANNELS];
	logic [CHANNELS-1:0] written_q;
	chan_state_t      rd_data_q;
	logic             rd_written_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	// entries never written read as normal mode, count zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr.en) begin
				written_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rd_written_q <= written_q[rd.addr];
			end
		end
	end

	assign rd_data = rd_written_q ? rd_data_q : chan_state_t'{mode: MODE_NORMAL, count: '0};

endmodule

// ===== rtl/sflm_core.sv =====
module sflm_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sflm_pkg::cfg_t        cfg,
	sflm_in_if.sink               item_in,
	sflm_out_if.source            result_out,
	output sflm_pkg::ram_rd_t     ram_rd,
	output sflm_pkg::ram_wr_t     ram_wr,
	input  sflm_pkg::chan_state_t ram_rd_data
);
	import sflm_pkg::*;

	logic        accept;
	logic        adv;
	logic        over0;
	mode_t       cls0;

	logic             vld_s1;
	logic [CH_W-1:0]  ch_s1;
	mode_t            cls_s1;
	logic             over_s1;
	logic             last_s1;

	logic             fwd_vld_q;
	logic [CH_W-1:0]  fwd_ch_q;
	chan_state_t      fwd_q;

	logic [PHASE_W-1:0] phase_q;
	logic               over_seen_q;

	logic             res_vld_q;
	led_t             led_q;
	mode_t            mode_q;
	logic             relay_upd_q;
	logic             relay_on_q;

	chan_state_t      cur;
	chan_state_t      nxt;
	logic             ch_ok;
	logic [CNT_W-1:0] cnt_inc;
	led_t             led;
	led_t             led_mode;
	mode_t            mode_out;
	logic             over_any;

	assign adv    = vld_s1 & (~res_vld_q | result_out.ready);
	assign item_in.ready = ~vld_s1 | adv;
	assign accept = item_in.valid & item_in.ready;

	always_comb begin
		over0 = item_in.temperature > item_in.threshold;
		if (over0) begin
			cls0 = MODE_OVER;
		end else if (item_in.adc_mid > cfg.open_level) begin
			cls0 = MODE_OPEN;
		end else if (item_in.adc_mid < cfg.short_level) begin
			cls0 = MODE_SHORT;
		end else begin
			cls0 = MODE_NORMAL;
		end
	end

	assign ram_rd.en   = accept;
	assign ram_rd.addr = CH_AW'(item_in.channel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1   <= item_in.channel;
			cls_s1  <= cls0;
			over_s1 <= over0;
			last_s1 <= item_in.scan_last;
		end
	end

	// read-modify-write of the channel entry
	always_comb begin
		ch_ok   = 32'(ch_s1) < CHANNELS;
		cur     = (fwd_vld_q && fwd_ch_q == ch_s1) ? fwd_q : ram_rd_data;
		cnt_inc = (cur.count == CNT_MAX) ? CNT_MAX : cur.count + 1'b1;
		nxt     = cur;

		case (cls_s1)
			MODE_OPEN:  led_mode = LED_ON;
			MODE_SHORT: led_mode = phase_q[1] ? LED_OFF : LED_ON;
			MODE_OVER: begin
				if (phase_q < SLOW_HALF) begin
					led_mode = LED_ON;
				end else if (phase_q < SLOW_PERIOD) begin
					led_mode = LED_OFF;
				end else begin
					led_mode = LED_KEEP;
				end
			end
			default:    led_mode = LED_OFF;
		endcase

		led = LED_KEEP;
		if (cur.mode == cls_s1) begin
			led = led_mode;
		end else if (cnt_inc > {1'b0, cfg.confirm_count}) begin
			nxt.mode  = cls_s1;
			nxt.count = '0;
			led       = led_mode;
		end else begin
			nxt.count = cnt_inc;
		end

		mode_out = nxt.mode;
		if (!ch_ok) begin
			led      = LED_KEEP;
			mode_out = MODE_NORMAL;
		end

		over_any = over_seen_q | over_s1;
	end

	assign ram_wr.en   = adv & ch_ok;
	assign ram_wr.addr = CH_AW'(ch_s1);
	assign ram_wr.data = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q   <= 1'b0;
			phase_q     <= '0;
			over_seen_q <= 1'b0;
			res_vld_q   <= 1'b0;
		end else begin
			if (adv && ch_ok) begin
				fwd_vld_q <= 1'b1;
			end
			if (adv) begin
				res_vld_q <= 1'b1;
				if (last_s1) begin
					over_seen_q <= 1'b0;
					phase_q     <= (phase_q >= PHASE_LAST) ? '0 : phase_q + 1'b1;
				end else begin
					over_seen_q <= over_any;
				end
			end else if (result_out.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ch_ok) begin
			fwd_ch_q <= ch_s1;
			fwd_q    <= nxt;
		end
		if (adv) begin
			led_q       <= led;
			mode_q      <= mode_out;
			relay_upd_q <= last_s1;
			relay_on_q  <= last_s1 & over_any;
		end
	end

	assign result_out.valid        = res_vld_q;
	assign result_out.led_action   = led_q;
	assign result_out.mode_now     = mode_q;
	assign result_out.relay_update = relay_upd_q;
	assign result_out.relay_on     = relay_on_q;

endmodule

// ===== rtl/sensor_fault_led_mode_monitor.sv =====
// Path: the accepting edge loads the state memory read and the input stage; the word
// then moves into the output register once that register is free or being taken.
// Throughput: one word per cycle while result words are taken; the per-channel read-modify-write
// of the state memory closes through a forwarding register for back-to-back channels.
// Reset: configuration returns to 3500 / 10 / 3, blink phase and relay tracking clear,
// and every channel entry reads as normal mode with a zero count until first written.
module sensor_fault_led_mode_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sflm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sflm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	sflm_in_if.sink                         item_in,
	sflm_out_if.source                      result_out
);
	import sflm_pkg::*;

	cfg_t        cfg;
	ram_rd_t     ram_rd;
	ram_wr_t     ram_wr;
	chan_state_t ram_rd_data;

	// Thresholds, confirm count: to be written only while the block is idle; left to the user.
	sflm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Per-channel display mode and mismatch counter. Read on accept,
	// written back when the word leaves the update stage.
	sflm_state_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (ram_rd),
		.wr      (ram_wr),
		.rd_data (ram_rd_data)
	);

	// Classify, update the channel entry, pick the LED action, track the
	// relay and blink phase over a scan, and hold the result word until taken.
	sflm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.item_in     (item_in),
		.result_out  (result_out),
		.ram_rd      (ram_rd),
		.ram_wr      (ram_wr),
		.ram_rd_data (ram_rd_data)
	);

endmodule
